// File: design/abff_pkg.sv
// abff_pkg: shared types and constants of the allocation bitmap block
// operation codes, sequencer states and fixed field widths
// no dependencies
`timescale 1ns / 1ps

package abff_pkg;

    // fixed field widths
    localparam int OP_W     = 4;
    localparam int IDX_W    = 10;
    localparam int CFG_W    = 5;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int RECIP_SH = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_SET      = 4'd0,
        OP_CLEAR    = 4'd1,
        OP_TEST     = 4'd2,
        OP_FIND_SET = 4'd3,
        OP_FIND_CLR = 4'd4,
        OP_SET_ALL  = 4'd5,
        OP_CLR_ALL  = 4'd6,
        OP_ALL_CLR  = 4'd7,
        OP_ALL_SET  = 4'd8
    } abff_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_BIT,
        ST_SCAN,
        ST_FILL,
        ST_DONE
    } abff_state_t;

endpackage

// File: design/abff_word_store.sv
// abff_word_store: bitmap word memory with per-word valid bits
// one write and one registered read per cycle; a word never written reads as zero
// no dependencies
`timescale 1ns / 1ps

module abff_word_store #(
    parameter int WORD_BITS = 64,
    parameter int WORDS     = 16,
    parameter int AW        = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem_reg [WORDS];
    logic [WORDS-1:0]     vld_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: design/abff_prio_enc.sv
// abff_prio_enc: lowest-set-bit priority encoder over one bitmap word
// no dependencies
`timescale 1ns / 1ps

module abff_prio_enc #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]         hits,
    output logic [$clog2(WORD_BITS)-1:0] pos,
    output logic                         any
);

    localparam int PSW = $clog2(WORD_BITS);

    always_comb
    begin
        pos = '0;
        // walk downward so the lowest hit wins
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                pos = PSW'(i);
            end
        end
    end

    assign any = |hits;

endmodule

// File: design/allocation_bitmap_find_first.sv
// allocation_bitmap_find_first: top level of the block-allocation bitmap
// depends on abff_pkg, abff_word_store and abff_prio_enc
`timescale 1ns / 1ps

// usage
//   s_axis carries one operation word: op in bits 3:0, bit_index in bits 13:4
//   m_axis returns exactly one result word per operation: flag in bit 0,
//   found_index in bits 10:1
//   cfg_wen/cfg_wdata load words_in_use (live word count, saturates to WORDS);
//   write it only while no operation is outstanding
// timing
//   one operation at a time; s_axis_tready is high only while the sequencer idles
//   set, clear, test: from acceptance to the result register the steps are
//   reciprocal divide, index fix-up and word read, modify/write, result load
//   find, all-clear, all-set: one word per cycle through the shared word read
//   port and priority encoder, stopping early on a hit
//   set all, clear all: one word written per cycle
//   the sequencer passes back through idle before the next word is taken
// reset
//   rst_n clears all valid bits, so the whole bitmap reads as zero at once;
//   words_in_use returns to 16
// back-pressure
//   the result sits in an output register; the next operation may be accepted
//   while it waits, and the sequencer holds in its final state until it drains

module allocation_bitmap_find_first #(
    parameter int WORD_BITS = 64,
    parameter int WORDS     = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [abff_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // op [3:0], bit_index [13:4], zero [15:14]
    input  logic [abff_pkg::IN_W-1:0]            s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // flag [0], found_index [10:1], zero [15:11]
    output logic [abff_pkg::OUT_W-1:0]           m_axis_tdata
);

    localparam int IDX_W    = abff_pkg::IDX_W;
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MAX_LIVE = (WORDS < 31) ? WORDS : 31;
    localparam int CNT_W    = $clog2(MAX_LIVE + 1);
    localparam int PSW      = $clog2(WORD_BITS);
    localparam int QW       = $clog2(1023 / WORD_BITS + 1);
    localparam int RECIP    = (1 << abff_pkg::RECIP_SH) / WORD_BITS;
    localparam int PW       = IDX_W + $clog2(RECIP + 1);

    // sequencer and working registers
    abff_pkg::abff_state_t state_reg, state_next;
    abff_pkg::abff_op_t    op_reg, op_next;
    logic [IDX_W-1:0]      bit_reg, bit_next;
    logic [QW-1:0]         q_reg, q_next;
    logic [AW-1:0]         word_reg, word_next;
    logic [PSW-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                  res_flag_reg, res_flag_next;
    logic [IDX_W-1:0]      res_idx_reg, res_idx_next;
    logic                  out_vld_reg, out_vld_next;
    logic                  out_flag_reg, out_flag_next;
    logic [IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic [abff_pkg::CFG_W-1:0] cfg_reg;

    // datapath signals
    logic [CNT_W-1:0]      live_cnt;
    abff_pkg::abff_op_t    in_op;
    logic [PW-1:0]         prod;
    logic [IDX_W-1:0]      rem_wide;
    logic [QW-1:0]         q_fix;
    logic [PSW-1:0]        pos_fix;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_BITS-1:0]  rd_word;
    logic [WORD_BITS-1:0]  bit_mask;
    logic [WORD_BITS-1:0]  enc_hits;
    logic [PSW-1:0]        enc_pos;
    logic                  enc_any;
    logic                  want_ones;

    // live count saturates at the number of words held
    assign live_cnt = (32'(cfg_reg) > MAX_LIVE) ? CNT_W'(MAX_LIVE) : CNT_W'(cfg_reg);

    assign in_op = abff_pkg::abff_op_t'(s_axis_tdata[abff_pkg::OP_W-1:0]);

    // word number by reciprocal multiply; the estimate is at most one low
    assign prod     = PW'(bit_reg) * PW'(RECIP);
    assign rem_wide = bit_reg - IDX_W'(32'(q_reg) * WORD_BITS);

    always_comb
    begin
        if (rem_wide >= IDX_W'(WORD_BITS))
        begin
            q_fix   = q_reg + QW'(1);
            pos_fix = PSW'(rem_wide - IDX_W'(WORD_BITS));
        end
        else
        begin
            q_fix   = q_reg;
            pos_fix = PSW'(rem_wide);
        end
    end

    assign bit_mask = WORD_BITS'(1) << pos_reg;

    // the shared encoder looks for ones in the word or in its complement
    assign want_ones = (op_reg == abff_pkg::OP_FIND_SET) || (op_reg == abff_pkg::OP_ALL_CLR);
    assign enc_hits  = want_ones ? rd_word : ~rd_word;

    abff_word_store #(
        .WORD_BITS (WORD_BITS),
        .WORDS     (WORDS),
        .AW        (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (rd_word)
    );

    abff_prio_enc #(
        .WORD_BITS (WORD_BITS)
    ) u_enc (
        .hits (enc_hits),
        .pos  (enc_pos),
        .any  (enc_any)
    );

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        bit_next      = bit_reg;
        q_next        = q_reg;
        word_next     = word_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        chk_vld_next  = chk_vld_reg;
        chk_idx_next  = chk_idx_reg;
        res_flag_next = res_flag_reg;
        res_idx_next  = res_idx_reg;
        out_vld_next  = out_vld_reg && !m_axis_tready;
        out_flag_next = out_flag_reg;
        out_idx_next  = out_idx_reg;
        mem_we        = 1'b0;
        mem_waddr     = word_reg;
        mem_wdata     = '0;
        mem_raddr     = '0;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            abff_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next       = in_op;
                    bit_next      = s_axis_tdata[abff_pkg::OP_W +: IDX_W];
                    cnt_next      = '0;
                    chk_vld_next  = 1'b0;
                    res_flag_next = 1'b0;
                    res_idx_next  = '0;
                    unique case (in_op) inside
                        abff_pkg::OP_SET, abff_pkg::OP_CLEAR, abff_pkg::OP_TEST:
                        begin
                            state_next = abff_pkg::ST_DIV;
                        end
                        abff_pkg::OP_FIND_SET, abff_pkg::OP_FIND_CLR,
                        abff_pkg::OP_ALL_CLR, abff_pkg::OP_ALL_SET:
                        begin
                            state_next = abff_pkg::ST_SCAN;
                        end
                        abff_pkg::OP_SET_ALL, abff_pkg::OP_CLR_ALL:
                        begin
                            state_next = abff_pkg::ST_FILL;
                        end
                        default:
                        begin
                            // unused code: empty result, bitmap left unchanged
                            state_next = abff_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            abff_pkg::ST_DIV:
            begin
                q_next     = QW'(prod >> abff_pkg::RECIP_SH);
                state_next = abff_pkg::ST_ADDR;
            end

            abff_pkg::ST_ADDR:
            begin
                if (32'(q_fix) < 32'(live_cnt))
                begin
                    mem_raddr  = AW'(q_fix);
                    word_next  = AW'(q_fix);
                    pos_next   = pos_fix;
                    state_next = abff_pkg::ST_BIT;
                end
                else
                begin
                    // beyond the live bits: ignored, test reads 0
                    state_next = abff_pkg::ST_DONE;
                end
            end

            abff_pkg::ST_BIT:
            begin
                mem_waddr = word_reg;
                if (op_reg == abff_pkg::OP_SET)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_word | bit_mask;
                end
                else if (op_reg == abff_pkg::OP_CLEAR)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_word & ~bit_mask;
                end
                else
                begin
                    res_flag_next = |(rd_word & bit_mask);
                end
                state_next = abff_pkg::ST_DONE;
            end

            abff_pkg::ST_SCAN:
            begin
                // read of word cnt overlaps the check of the word read last cycle
                if (chk_vld_reg && enc_any)
                begin
                    chk_vld_next = 1'b0;
                    state_next   = abff_pkg::ST_DONE;
                    if ((op_reg == abff_pkg::OP_FIND_SET) || (op_reg == abff_pkg::OP_FIND_CLR))
                    begin
                        res_flag_next = 1'b1;
                        res_idx_next  = IDX_W'(32'(chk_idx_reg) * WORD_BITS + 32'(enc_pos));
                    end
                    else
                    begin
                        res_flag_next = 1'b0;
                    end
                end
                else if (!chk_vld_reg && (cnt_reg == live_cnt))
                begin
                    // ran off the live words with no hit
                    state_next    = abff_pkg::ST_DONE;
                    res_flag_next = (op_reg == abff_pkg::OP_ALL_CLR) ||
                                    (op_reg == abff_pkg::OP_ALL_SET);
                end
                else if (cnt_reg != live_cnt)
                begin
                    mem_raddr    = AW'(cnt_reg);
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_reg;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
            end

            abff_pkg::ST_FILL:
            begin
                if (cnt_reg == live_cnt)
                begin
                    state_next = abff_pkg::ST_DONE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(cnt_reg);
                    mem_wdata = (op_reg == abff_pkg::OP_SET_ALL) ? '1 : '0;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end

            abff_pkg::ST_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_flag_next = res_flag_reg;
                    out_idx_next  = res_idx_reg;
                    state_next    = abff_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = abff_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= abff_pkg::ST_IDLE;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            cfg_reg     <= abff_pkg::CFG_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wen)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        bit_reg      <= bit_next;
        q_reg        <= q_next;
        word_reg     <= word_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        chk_idx_reg  <= chk_idx_next;
        res_flag_reg <= res_flag_next;
        res_idx_reg  <= res_idx_next;
        out_flag_reg <= out_flag_next;
        out_idx_reg  <= out_idx_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(abff_pkg::OUT_W - IDX_W - 1){1'b0}}, out_idx_reg, out_flag_reg};

`ifndef SYNTHESIS
    // a result only appears out of the final sequencer state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == abff_pkg::ST_DONE))
        else $error("result word appeared outside the done state");

    // an accepted word always starts the sequencer
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != abff_pkg::ST_IDLE))
        else $error("accepted word did not leave idle");

    // the scan pipeline holds a pending word only while scanning
    a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == abff_pkg::ST_SCAN))
        else $error("pending scan word outside the scan state");
`endif

endmodule

// File: dv/tb_allocation_bitmap_find_first.sv
// tb_allocation_bitmap_find_first: self-checking bench for the allocation bitmap block
// directed table then random alloc/free traffic, checked against a shadow bitmap
// depends on abff_pkg and allocation_bitmap_find_first
`timescale 1ns / 1ps

module tb_allocation_bitmap_find_first;

    localparam int WORD_BITS  = 64;
    localparam int WORDS      = 16;
    localparam int CLK_HALF   = 6;
    localparam int STALL_MAX  = 4000;   // cycles with no word moving on either side
    localparam int DRAIN_WAIT = 24;     // longest scan plus sequencer overhead
    localparam int SEG_ITEMS  = 133;
    localparam int N_SEGS     = 4;
    localparam int N_DIR      = 36;

    // codes outside the defined operations, the block must answer with zeros
    localparam logic [abff_pkg::OP_W-1:0] OP_SPARE_LO = 4'd9;
    localparam logic [abff_pkg::OP_W-1:0] OP_SPARE_HI = 4'd15;

    // input word, packed from the lowest bit up: op, bit_index, pad
    typedef struct packed {
        logic [1:0]                 pad;
        logic [abff_pkg::IDX_W-1:0] bit_index;
        logic [abff_pkg::OP_W-1:0]  op;
    } op_word_t;

    // result word, packed from the lowest bit up: flag, found_index, pad
    typedef struct packed {
        logic [4:0]                 pad;
        logic [abff_pkg::IDX_W-1:0] found_index;
        logic                       flag;
    } result_word_t;

    // one row of the directed table: either a live-count write or an operation
    typedef struct packed {
        logic                       is_cfg;
        logic [abff_pkg::CFG_W-1:0] cfg_val;
        logic [abff_pkg::OP_W-1:0]  op;
        logic [abff_pkg::IDX_W-1:0] bit_index;
        logic                       typed;      // expectation given in the row
        logic                       flag;
        logic [abff_pkg::IDX_W-1:0] found_index;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wen = 1'b0;
    logic [abff_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // op [3:0], bit_index [13:4], zero [15:14]
    logic [abff_pkg::IN_W-1:0]     s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // flag [0], found_index [10:1], zero [15:11]
    logic [abff_pkg::OUT_W-1:0]    m_axis_tdata;

    // shadow of the block's state
    logic [WORD_BITS-1:0]          shadow_words [WORDS];
    logic [abff_pkg::CFG_W-1:0]    shadow_live_cfg;

    result_word_t pending_results [$];
    result_word_t last_answer;
    int           fault_count = 0;
    int           stall_run = 0;
    int           src_idle_pct = 27;
    int           sink_idle_pct = 57;

    // stimulus table: reset state, extremes, spare codes, then live-count corners
    dir_row_t dir_rows [N_DIR] = '{
        '{1'b0, 5'd0, abff_pkg::OP_ALL_CLR, 10'd0, 1'b1, 1'b1, 10'd0},    // fresh bitmap is empty
        '{1'b0, 5'd0, abff_pkg::OP_ALL_SET, 10'd0, 1'b1, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_FIND_SET, 10'd0, 1'b1, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_FIND_CLR, 10'd0, 1'b1, 1'b1, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_TEST, 10'd1023, 1'b1, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_SET, 10'd0, 1'b1, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_SET, 10'd1023, 1'b1, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_TEST, 10'd1023, 1'b1, 1'b1, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_FIND_SET, 10'd0, 1'b1, 1'b1, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_CLEAR, 10'd0, 1'b1, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_FIND_SET, 10'd0, 1'b1, 1'b1, 10'd1023}, // last word, top bit
        '{1'b0, 5'd0, abff_pkg::OP_SET_ALL, 10'd0, 1'b0, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_ALL_SET, 10'd0, 1'b1, 1'b1, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_FIND_CLR, 10'd0, 1'b1, 1'b0, 10'd0},   // full bitmap
        '{1'b0, 5'd0, abff_pkg::OP_CLEAR, 10'd512, 1'b0, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_FIND_CLR, 10'd0, 1'b1, 1'b1, 10'd512},
        '{1'b0, 5'd0, abff_pkg::OP_CLR_ALL, 10'd0, 1'b0, 1'b0, 10'd0},
        '{1'b0, 5'd0, OP_SPARE_LO, 10'd1023, 1'b1, 1'b0, 10'd0},
        '{1'b0, 5'd0, OP_SPARE_HI, 10'h2AA, 1'b1, 1'b0, 10'd0},
        '{1'b1, 5'd2, abff_pkg::OP_SET, 10'd0, 1'b0, 1'b0, 10'd0},       // two live words
        '{1'b0, 5'd0, abff_pkg::OP_SET, 10'd200, 1'b0, 1'b0, 10'd0},     // beyond live bits
        '{1'b0, 5'd0, abff_pkg::OP_TEST, 10'd200, 1'b1, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_SET_ALL, 10'd0, 1'b0, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_ALL_SET, 10'd0, 1'b1, 1'b1, 10'd0},
        '{1'b1, 5'd0, abff_pkg::OP_SET, 10'd0, 1'b0, 1'b0, 10'd0},       // nothing live
        '{1'b0, 5'd0, abff_pkg::OP_ALL_CLR, 10'd0, 1'b1, 1'b1, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_ALL_SET, 10'd0, 1'b1, 1'b1, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_FIND_SET, 10'd0, 1'b1, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_FIND_CLR, 10'd0, 1'b1, 1'b0, 10'd0},
        '{1'b1, 5'd31, abff_pkg::OP_SET, 10'd0, 1'b0, 1'b0, 10'd0},      // saturates to all words
        '{1'b0, 5'd0, abff_pkg::OP_FIND_CLR, 10'd0, 1'b1, 1'b1, 10'd128}, // words past two clear
        '{1'b0, 5'd0, abff_pkg::OP_TEST, 10'd200, 1'b1, 1'b0, 10'd0},
        '{1'b1, 5'd1, abff_pkg::OP_SET, 10'd0, 1'b0, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_CLR_ALL, 10'd0, 1'b0, 1'b0, 10'd0},
        '{1'b1, 5'd17, abff_pkg::OP_SET, 10'd0, 1'b0, 1'b0, 10'd0},
        '{1'b0, 5'd0, abff_pkg::OP_FIND_SET, 10'd0, 1'b1, 1'b1, 10'd64}   // word 1 still full
    };

    // live-count plan for the random segments, a zero entry means pick at random
    int seg_cfg_plan [N_SEGS * 3] = '{16, 1, 0, 31, 17, 0, 3, 2, 16, 0, 8, 0};

    allocation_bitmap_find_first #(
        .WORD_BITS (WORD_BITS),
        .WORDS     (WORDS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // work out the answer to one operation and update the shadow bitmap
    function automatic result_word_t predict_bitmap_result(
        input logic [abff_pkg::OP_W-1:0]  op,
        input logic [abff_pkg::IDX_W-1:0] bit_index);
        result_word_t         res;
        int                   live;
        int                   word_sel;
        int                   bit_pos;
        int                   i;
        int                   b;
        logic [WORD_BITS-1:0] cand;
        res      = '0;
        live     = (int'(shadow_live_cfg) > WORDS) ? WORDS : int'(shadow_live_cfg);
        word_sel = int'(bit_index) / WORD_BITS;
        bit_pos  = int'(bit_index) % WORD_BITS;
        case (op)
            abff_pkg::OP_SET:
                if (word_sel < live)
                    shadow_words[word_sel][bit_pos] = 1'b1;
            abff_pkg::OP_CLEAR:
                if (word_sel < live)
                    shadow_words[word_sel][bit_pos] = 1'b0;
            abff_pkg::OP_TEST:
                if (word_sel < live)
                    res.flag = shadow_words[word_sel][bit_pos];
            abff_pkg::OP_FIND_SET, abff_pkg::OP_FIND_CLR:
            begin
                for (i = 0; i < live; i++)
                begin
                    cand = (op == abff_pkg::OP_FIND_SET) ? shadow_words[i] : ~shadow_words[i];
                    for (b = 0; b < WORD_BITS; b++)
                    begin
                        if (!res.flag && cand[b])
                        begin
                            res.flag        = 1'b1;
                            res.found_index = abff_pkg::IDX_W'(i * WORD_BITS + b);
                        end
                    end
                end
            end
            abff_pkg::OP_SET_ALL:
                for (i = 0; i < live; i++)
                    shadow_words[i] = '1;
            abff_pkg::OP_CLR_ALL:
                for (i = 0; i < live; i++)
                    shadow_words[i] = '0;
            abff_pkg::OP_ALL_CLR:
            begin
                res.flag = 1'b1;
                for (i = 0; i < live; i++)
                    if (shadow_words[i] != '0)
                        res.flag = 1'b0;
            end
            abff_pkg::OP_ALL_SET:
            begin
                res.flag = 1'b1;
                for (i = 0; i < live; i++)
                    if (shadow_words[i] != '1)
                        res.flag = 1'b0;
            end
            default: ;   // spare codes leave state alone and answer zero
        endcase
        return res;
    endfunction

    // present one operation word; tvalid stays high into the next call unless a gap is drawn
    task automatic send_op(input logic [abff_pkg::OP_W-1:0] op,
                           input logic [abff_pkg::IDX_W-1:0] bit_index,
                           input logic typed, input result_word_t typed_res);
        op_word_t     word;
        result_word_t res;
        word           = '0;
        word.op        = op;
        word.bit_index = bit_index;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= abff_pkg::IN_W'($urandom);   // junk while idle
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = predict_bitmap_result(op, bit_index);
        last_answer = res;
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // let the block settle, then load a new live word count
    task automatic write_live_words(input logic [abff_pkg::CFG_W-1:0] words);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= words;
        @(posedge clk);
        shadow_live_cfg = words;
        cfg_wen   <= 1'b0;
        cfg_wdata <= abff_pkg::CFG_W'($urandom);
    endtask

    // bit index mostly inside the live bits, now and then anywhere in the field
    function automatic logic [abff_pkg::IDX_W-1:0] pick_index();
        int live;
        live = (int'(shadow_live_cfg) > WORDS) ? WORDS : int'(shadow_live_cfg);
        if (live == 0 || $urandom_range(0, 99) < 20)
            return abff_pkg::IDX_W'($urandom);
        return abff_pkg::IDX_W'($urandom_range(0, live * WORD_BITS - 1));
    endfunction

    // one burst of random traffic: allocate and free sequences around point operations
    task automatic run_segment(input int items);
        int n;
        int r;
        n = 0;
        while (n < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                // allocate: find a free bit, then claim it
                send_op(abff_pkg::OP_FIND_CLR, pick_index(), 1'b0, '0);
                n++;
                if (last_answer.flag)
                begin
                    send_op(abff_pkg::OP_SET, last_answer.found_index, 1'b0, '0);
                    n++;
                end
            end
            else if (r < 45)
            begin
                // free: find a used bit, then release it
                send_op(abff_pkg::OP_FIND_SET, pick_index(), 1'b0, '0);
                n++;
                if (last_answer.flag)
                begin
                    send_op(abff_pkg::OP_CLEAR, last_answer.found_index, 1'b0, '0);
                    n++;
                end
            end
            else
            begin
                if (r < 60)
                    send_op(abff_pkg::OP_SET, pick_index(), 1'b0, '0);
                else if (r < 70)
                    send_op(abff_pkg::OP_CLEAR, pick_index(), 1'b0, '0);
                else if (r < 82)
                    send_op(abff_pkg::OP_TEST, pick_index(), 1'b0, '0);
                else if (r < 86)
                    send_op(abff_pkg::OP_ALL_CLR, pick_index(), 1'b0, '0);
                else if (r < 90)
                    send_op(abff_pkg::OP_ALL_SET, pick_index(), 1'b0, '0);
                else if (r < 92)
                    send_op(abff_pkg::OP_SET_ALL, pick_index(), 1'b0, '0);
                else if (r < 94)
                    send_op(abff_pkg::OP_CLR_ALL, pick_index(), 1'b0, '0);
                else if (r < 97)
                    send_op(($urandom_range(0, 1) != 0) ? abff_pkg::OP_FIND_SET
                                                        : abff_pkg::OP_FIND_CLR,
                            pick_index(), 1'b0, '0);
                else
                    send_op(abff_pkg::OP_W'($urandom_range(int'(OP_SPARE_LO),
                                                           int'(OP_SPARE_HI))),
                            abff_pkg::IDX_W'($urandom), 1'b0, '0);
                n++;
            end
        end
    endtask

    // result side: random back-pressure and in-order comparison
    initial
    begin
        result_word_t got;
        result_word_t want;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (pending_results.size() == 0)
                begin
                    $error("result word with no operation outstanding: %h", got);
                    fault_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.flag !== want.flag)
                    begin
                        $error("flag: expected %0d, got %0d", want.flag, got.flag);
                        fault_count++;
                    end
                    if (got.found_index !== want.found_index)
                    begin
                        $error("found_index: expected %0d, got %0d",
                               want.found_index, got.found_index);
                        fault_count++;
                    end
                    if (got.pad !== want.pad)
                    begin
                        $error("pad: expected %h, got %h", want.pad, got.pad);
                        fault_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // watchdog: counts cycles in which no word moves on either side
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_run = 0;
            else
                stall_run++;
            if (stall_run >= STALL_MAX)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int           k;
        int           m;
        int           s;
        int           cfg_pick;
        result_word_t typed_res;
        for (k = 0; k < WORDS; k++)
            shadow_words[k] = '0;
        shadow_live_cfg = abff_pkg::CFG_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the first idling mix
        for (k = 0; k < N_DIR; k++)
        begin
            if (dir_rows[k].is_cfg)
                write_live_words(dir_rows[k].cfg_val);
            else
            begin
                typed_res             = '0;
                typed_res.flag        = dir_rows[k].flag;
                typed_res.found_index = dir_rows[k].found_index;
                send_op(dir_rows[k].op, dir_rows[k].bit_index, dir_rows[k].typed, typed_res);
            end
        end

        // random traffic: receiver-heavy idling, sender-heavy idling, then none
        for (m = 0; m < 3; m++)
        begin
            src_idle_pct  = (m == 0) ? 27 : (m == 1) ? 57 : 0;
            sink_idle_pct = (m == 0) ? 57 : (m == 1) ? 27 : 0;
            for (s = 0; s < N_SEGS; s++)
            begin
                cfg_pick = seg_cfg_plan[m * N_SEGS + s];
                if (cfg_pick == 0)
                    cfg_pick = $urandom_range(1, WORDS);
                write_live_words(abff_pkg::CFG_W'(cfg_pick));
                // an occasional wipe so finds see both sparse and crowded maps
                if ($urandom_range(0, 1) != 0)
                    send_op(abff_pkg::OP_CLR_ALL, '0, 1'b0, '0);
                run_segment(SEG_ITEMS);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT + 8) @(posedge clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
design/abff_pkg.sv
design/abff_word_store.sv
design/abff_prio_enc.sv
design/allocation_bitmap_find_first.sv
dv/tb_allocation_bitmap_find_first.sv
